// ----- rtl/csa_pkg.sv -----
package csa_pkg;

    localparam int COL_W   = 11;
    localparam int NCOL_W  = 12;
    localparam int ROWS_W  = 32;
    localparam int SAMP_W  = 32;
    localparam int SUM_W   = 64;
    localparam int SQ_W    = 63;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_ACCUMULATE = 2'd0;
    localparam logic [OP_W-1:0] OP_MERGE      = 2'd1;
    localparam logic [OP_W-1:0] OP_READ       = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_ROWS  = 1'd1;

    localparam int MQ_DEPTH = 4;
    localparam int OQ_DEPTH = 4;
    localparam int QCW      = $clog2(MQ_DEPTH + 1);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic                    ok;
        logic [COL_W-1:0]        column;
        logic signed [SUM_W-1:0] sum_add;
        logic [SQ_W-1:0]         sq_add;
    } t_work;

    typedef struct packed {
        logic                    status;
        logic signed [SUM_W-1:0] column_sum;
        logic [SQ_W-1:0]         column_sumsq;
    } t_result;

endpackage

// ----- rtl/column_sum_sumsq_accumulator.sv -----
// Channel   Handshake                 Payload
// input     push / full               i_op, i_column, i_sample, i_partial_sum, i_partial_sumsq
// result    pop / empty               o_status, o_column_sum, o_column_sumsq, o_row_total
// config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle is sustained while results are popped and the stores are not clearing;
// a result passes the front registers, the work queue and the back stage into the output queue.
// The rate is set by the read-modify-write of the column stores, which forwards the
// previous write so back-to-back items on one column see each other's totals.
// After reset the stores are zeroed, address by address up to MAX_COLUMNS-1, during which full is high.
// A stalled result side fills the output queue, then the work queue, then raises full.
module column_sum_sumsq_accumulator #(
    parameter int MAX_COLUMNS      = 2048,
    parameter int SAMPLE_FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [csa_pkg::OP_W-1:0]              i_op,
    input  logic [csa_pkg::COL_W-1:0]             i_column,
    input  logic signed [csa_pkg::SAMP_W-1:0]     i_sample,
    input  logic signed [csa_pkg::SUM_W-1:0]      i_partial_sum,
    input  logic [csa_pkg::SQ_W-1:0]              i_partial_sumsq,
    output logic                                  empty,
    input  logic                                  pop,
    output logic                                  o_status,
    output logic signed [csa_pkg::SUM_W-1:0]      o_column_sum,
    output logic [csa_pkg::SQ_W-1:0]              o_column_sumsq,
    output logic [csa_pkg::ROWS_W-1:0]            o_row_total,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [csa_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [csa_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    logic [csa_pkg::NCOL_W-1:0] r_num_columns;
    logic [csa_pkg::ROWS_W-1:0] r_total_rows;
    logic                       accept;
    logic [1:0]                 front_pending;
    logic                       work_valid;
    csa_pkg::t_work             front_work;
    csa_pkg::t_work             mid_work;
    logic                       mid_empty;
    logic                       mid_pop;
    logic [csa_pkg::QCW-1:0]    mid_count;
    logic                       res_push;
    csa_pkg::t_result           res;
    csa_pkg::t_result           out_res;
    logic [csa_pkg::QCW-1:0]    out_count;
    logic                       clearing;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_columns <= csa_pkg::NCOL_W'(1);
            r_total_rows  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                csa_pkg::REG_NUM_COLUMNS: r_num_columns <= i_cfg_data[csa_pkg::NCOL_W-1:0];
                csa_pkg::REG_TOTAL_ROWS:  r_total_rows  <= i_cfg_data[csa_pkg::ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    assign full   = clearing ||
                    ((32'(mid_count) + 32'(front_pending)) >= 32'(csa_pkg::MQ_DEPTH));
    assign accept = push && !full;

    csa_front #(
        .MAX_COLUMNS      (MAX_COLUMNS),
        .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_op            (i_op),
        .i_column        (i_column),
        .i_sample        (i_sample),
        .i_partial_sum   (i_partial_sum),
        .i_partial_sumsq (i_partial_sumsq),
        .i_num_columns   (r_num_columns),
        .o_pending       (front_pending),
        .o_work_valid    (work_valid),
        .o_work          (front_work)
    );

    csa_fifo #(
        .WIDTH ($bits(csa_pkg::t_work)),
        .DEPTH (csa_pkg::MQ_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (work_valid),
        .i_data  (front_work),
        .i_pop   (mid_pop),
        .o_data  (mid_work),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    csa_back #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work       (mid_work),
        .i_work_empty (mid_empty),
        .o_work_pop   (mid_pop),
        .i_res_count  (out_count),
        .o_res_push   (res_push),
        .o_res        (res),
        .o_clearing   (clearing)
    );

    csa_fifo #(
        .WIDTH ($bits(csa_pkg::t_result)),
        .DEPTH (csa_pkg::OQ_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .i_pop   (pop && !empty),
        .o_data  (out_res),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_status       = out_res.status;
    assign o_column_sum   = out_res.column_sum;
    assign o_column_sumsq = out_res.column_sumsq;
    assign o_row_total    = r_total_rows;

    a_mid_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        work_valid |-> (32'(mid_count) < 32'(csa_pkg::MQ_DEPTH)))
        else $error("work queue written while full");

    a_out_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> (32'(out_count) < 32'(csa_pkg::OQ_DEPTH)))
        else $error("result queue written while full");

    a_clear_blocks_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> (full && empty && mid_empty))
        else $error("item in flight during store clearing");

    a_bad_column_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status) |-> ((o_column_sum == '0) && (o_column_sumsq == '0)))
        else $error("out-of-range result carries nonzero totals");

endmodule

// ----- rtl/csa_ram.sv -----
module csa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/csa_fifo.sv -----
module csa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic [CW-1:0]    o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_rd_ptr;
    logic [PW-1:0]    r_wr_ptr;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             do_push;
    logic             do_pop;

    assign do_push = i_push && (r_count != CW'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

// ----- rtl/csa_front.sv -----
module csa_front #(
    parameter int MAX_COLUMNS      = 2048,
    parameter int SAMPLE_FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  logic [csa_pkg::OP_W-1:0]              i_op,
    input  logic [csa_pkg::COL_W-1:0]             i_column,
    input  logic signed [csa_pkg::SAMP_W-1:0]     i_sample,
    input  logic signed [csa_pkg::SUM_W-1:0]      i_partial_sum,
    input  logic [csa_pkg::SQ_W-1:0]              i_partial_sumsq,
    input  logic [csa_pkg::NCOL_W-1:0]            i_num_columns,
    output logic [1:0]                            o_pending,
    output logic                                  o_work_valid,
    output csa_pkg::t_work                        o_work
);

    logic                                r_f1_v;
    logic [csa_pkg::OP_W-1:0]            r_f1_op;
    logic                                r_f1_ok;
    logic [csa_pkg::COL_W-1:0]           r_f1_col;
    logic [csa_pkg::SAMP_W-1:0]          r_f1_sample;
    logic signed [csa_pkg::SUM_W-1:0]    r_f1_psum;
    logic [csa_pkg::SQ_W-1:0]            r_f1_psq;
    logic [csa_pkg::SAMP_W-1:0]          r_f1_mag;
    logic                                r_f2_v;
    csa_pkg::t_work                      r_f2_work;
    csa_pkg::t_work                      n_f2_work;
    logic                                in_range;
    logic [csa_pkg::SAMP_W-1:0]          mag;
    logic [2*csa_pkg::SAMP_W-1:0]        prod;
    logic [2*csa_pkg::SAMP_W-1:0]        sq_shift;

    assign in_range = (32'(i_column) < 32'(i_num_columns)) &&
                      (32'(i_column) < 32'(MAX_COLUMNS));
    assign mag = i_sample[csa_pkg::SAMP_W-1] ? (~i_sample + 1'b1) : i_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else begin
            r_f1_v <= i_accept;
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_op     <= i_op;
        r_f1_ok     <= in_range;
        r_f1_col    <= i_column;
        r_f1_sample <= i_sample;
        r_f1_psum   <= i_partial_sum;
        r_f1_psq    <= i_partial_sumsq;
        r_f1_mag    <= mag;
        r_f2_work   <= n_f2_work;
    end

    assign prod     = r_f1_mag * r_f1_mag;
    assign sq_shift = prod >> SAMPLE_FRAC_BITS;

    always_comb begin
        n_f2_work.ok     = r_f1_ok;
        n_f2_work.column = r_f1_col;
        unique case (r_f1_op)
            csa_pkg::OP_ACCUMULATE: begin
                n_f2_work.sum_add = {{(csa_pkg::SUM_W - csa_pkg::SAMP_W)
                                      {r_f1_sample[csa_pkg::SAMP_W-1]}}, r_f1_sample};
                n_f2_work.sq_add  = sq_shift[csa_pkg::SQ_W-1:0];
            end
            csa_pkg::OP_MERGE: begin
                n_f2_work.sum_add = r_f1_psum;
                n_f2_work.sq_add  = r_f1_psq;
            end
            default: begin
                n_f2_work.sum_add = '0;
                n_f2_work.sq_add  = '0;
            end
        endcase
        if (!r_f1_ok) begin
            n_f2_work.sum_add = '0;
            n_f2_work.sq_add  = '0;
        end
    end

    assign o_pending    = 2'(r_f1_v) + 2'(r_f2_v);
    assign o_work_valid = r_f2_v;
    assign o_work       = r_f2_work;

endmodule

// ----- rtl/csa_back.sv -----
module csa_back #(
    parameter int MAX_COLUMNS = 2048,
    localparam int AW         = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  csa_pkg::t_work             i_work,
    input  logic                       i_work_empty,
    output logic                       o_work_pop,
    input  logic [csa_pkg::QCW-1:0]    i_res_count,
    output logic                       o_res_push,
    output csa_pkg::t_result           o_res,
    output logic                       o_clearing
);

    logic                             r_clr_busy;
    logic [AW-1:0]                    r_clr_addr;
    logic                             r_b1_v;
    csa_pkg::t_work                   r_b1_work;
    logic                             r_wb_v;
    logic [AW-1:0]                    r_wb_addr;
    logic signed [csa_pkg::SUM_W-1:0] r_wb_sum;
    logic [csa_pkg::SQ_W-1:0]         r_wb_sq;
    logic [AW-1:0]                    rd_addr;
    logic [AW-1:0]                    b1_addr;
    logic [31:0]                      rd_col_ext;
    logic [31:0]                      b1_col_ext;
    logic signed [csa_pkg::SUM_W-1:0] ram_sum;
    logic [csa_pkg::SQ_W-1:0]         ram_sq;
    logic signed [csa_pkg::SUM_W-1:0] cur_sum;
    logic [csa_pkg::SQ_W-1:0]         cur_sq;
    logic signed [csa_pkg::SUM_W-1:0] raw_sum;
    logic                             sum_ovf;
    logic signed [csa_pkg::SUM_W-1:0] new_sum;
    logic [csa_pkg::SQ_W:0]           raw_sq;
    logic [csa_pkg::SQ_W-1:0]         new_sq;
    logic                             item_we;
    logic                             we;
    logic [AW-1:0]                    waddr;
    logic signed [csa_pkg::SUM_W-1:0] wsum;
    logic [csa_pkg::SQ_W-1:0]         wsq;

    assign o_work_pop = !i_work_empty && !r_clr_busy &&
                        ((32'(i_res_count) + 32'(r_b1_v)) < 32'(csa_pkg::OQ_DEPTH));

    assign rd_col_ext = 32'(i_work.column);
    assign b1_col_ext = 32'(r_b1_work.column);
    assign rd_addr    = rd_col_ext[AW-1:0];
    assign b1_addr    = b1_col_ext[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_b1_v     <= 1'b0;
            r_wb_v     <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(MAX_COLUMNS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_b1_v <= o_work_pop;
            r_wb_v <= item_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1_work <= i_work;
        r_wb_addr <= b1_addr;
        r_wb_sum  <= new_sum;
        r_wb_sq   <= new_sq;
    end

    // The previous write lands on the same edge as this item's read, so it is forwarded.
    assign cur_sum = (r_wb_v && (r_wb_addr == b1_addr)) ? r_wb_sum : ram_sum;
    assign cur_sq  = (r_wb_v && (r_wb_addr == b1_addr)) ? r_wb_sq : ram_sq;

    assign raw_sum = cur_sum + r_b1_work.sum_add;
    assign sum_ovf = (cur_sum[csa_pkg::SUM_W-1] == r_b1_work.sum_add[csa_pkg::SUM_W-1]) &&
                     (raw_sum[csa_pkg::SUM_W-1] != cur_sum[csa_pkg::SUM_W-1]);
    assign new_sum = sum_ovf ? (r_b1_work.sum_add[csa_pkg::SUM_W-1] ? csa_pkg::SUM_MIN
                                                                     : csa_pkg::SUM_MAX)
                             : raw_sum;
    assign raw_sq  = {1'b0, cur_sq} + {1'b0, r_b1_work.sq_add};
    assign new_sq  = raw_sq[csa_pkg::SQ_W] ? '1 : raw_sq[csa_pkg::SQ_W-1:0];

    assign item_we = r_b1_v && r_b1_work.ok;
    assign we      = r_clr_busy || item_we;
    assign waddr   = r_clr_busy ? r_clr_addr : b1_addr;
    assign wsum    = r_clr_busy ? '0 : new_sum;
    assign wsq     = r_clr_busy ? '0 : new_sq;

    csa_ram #(
        .WIDTH (csa_pkg::SUM_W),
        .DEPTH (MAX_COLUMNS)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wsum),
        .i_raddr (rd_addr),
        .o_rdata (ram_sum)
    );

    csa_ram #(
        .WIDTH (csa_pkg::SQ_W),
        .DEPTH (MAX_COLUMNS)
    ) u_sq_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wsq),
        .i_raddr (rd_addr),
        .o_rdata (ram_sq)
    );

    always_comb begin
        if (r_b1_work.ok) begin
            o_res.status       = 1'b0;
            o_res.column_sum   = new_sum;
            o_res.column_sumsq = new_sq;
        end else begin
            o_res.status       = 1'b1;
            o_res.column_sum   = '0;
            o_res.column_sumsq = '0;
        end
    end

    assign o_res_push = r_b1_v;
    assign o_clearing = r_clr_busy;

endmodule
